// ===== rtl/core/radical_simplifier_macros.svh =====
// Assertion macros shared by the radical simplifier checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef RADICAL_SIMPLIFIER_MACROS_SVH
`define RADICAL_SIMPLIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define RS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rs_pkg.sv =====
// Package for the radical simplifier: field widths, status codes and the
// divider status struct. Depends on nothing.
package rs_pkg;

  localparam int INPUT_BITS_DEF = 16;
  localparam int RADICAND_W     = 16;
  localparam int STATUS_W       = 2;
  localparam int OUTER_W        = 8;
  localparam int FIRST_PRIME    = 2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_SQUARE  = 2'd0,
    ST_REDUCED = 2'd1,
    ST_IRRED   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Status of the shared divider seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/rs_in_if.sv =====
// Input channel of the radical simplifier: valid/ready plus the radicand.
// Depends on rs_pkg.
interface rs_in_if;
  logic                           valid;
  logic                           ready;
  logic [rs_pkg::RADICAND_W-1:0]  radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

// ===== rtl/core/rs_out_if.sv =====
// Result channel of the radical simplifier: valid/ready plus status, m, n.
// Depends on rs_pkg.
interface rs_out_if;
  logic                           valid;
  logic                           ready;
  rs_pkg::status_t                status;
  logic [rs_pkg::OUTER_W-1:0]     outer_factor;
  logic [rs_pkg::RADICAND_W-1:0]  inner_radicand;

  modport source (output valid, output status, output outer_factor,
                  output inner_radicand, input ready);
  modport sink   (input valid, input status, input outer_factor,
                  input inner_radicand, output ready);
endinterface

// ===== rtl/core/rs_div.sv =====
// Shared restoring divider: one quotient bit per cycle, VAL_W bits per
// division. Depends on rs_pkg for the status struct.
module rs_div #(
  parameter int VAL_W = rs_pkg::INPUT_BITS_DEF,
  parameter int P_W   = (rs_pkg::INPUT_BITS_DEF + 1) / 2 + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VAL_W-1:0]  dividend,
  input  logic [P_W-1:0]    divisor,
  output rs_pkg::div_stat_t stat,
  output logic [VAL_W-1:0]  quot,
  output logic [P_W-1:0]    rem
);

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VAL_W-1:0]   quot_r, quot_nxt;
  logic [P_W-1:0]     rem_r, rem_nxt;
  logic [P_W-1:0]     div_r, div_nxt;
  logic [P_W:0]       trial;
  logic               fits;

  // Shift in the next dividend bit and test the divisor against it
  assign trial = {rem_r, quot_r[VAL_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VAL_W);
      quot_nxt = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[VAL_W-2:0], fits};
      rem_nxt  = fits ? P_W'(trial - {1'b0, div_r}) : P_W'(trial);
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;
  assign rem       = rem_r;

endmodule

// ===== rtl/core/radical_simplifier.sv =====
// Radical simplifier: writes sqrt(radicand) as m * sqrt(n), n square-free.
//
// Channels: in_ch takes one radicand per transfer (valid/ready); out_ch
// returns one result per input: status, outer factor m, inner radicand n.
// Status: perfect square (n = 1), reduced (m > 1), irreducible (m = 1) or
// invalid (zero input, m = n = 0). Only the low INPUT_BITS bits are used.
//
// The block factors by trial division from 2, one candidate p at a time,
// stopping once p*p exceeds the remaining value. Every trial runs on one
// shared restoring divider of width W = min(INPUT_BITS,16) and holds the
// block until it is done; each candidate adds a p*p step (S_SQ) and a
// compare step (S_CHK), and each pair or odd leftover of p a multiply step.
// A zero input goes straight to the result state. in_ch.ready is high only
// between items.
//
// The result sits in an output register; the block takes the next input
// while it waits, but holds the following result until out_ch transfers.
// Reset (synchronous, active low) drops any item in flight and clears the
// output valid.
module radical_simplifier #(
  parameter int INPUT_BITS = rs_pkg::INPUT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rs_in_if.sink    in_ch,
  rs_out_if.source out_ch
);

  localparam int VAL_W = (INPUT_BITS < rs_pkg::RADICAND_W) ? INPUT_BITS
                                                           : rs_pkg::RADICAND_W;
  localparam int P_W   = (VAL_W + 1) / 2 + 1;
  localparam int M_W   = (VAL_W + 1) / 2;
  localparam int PP_W  = 2 * P_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQ   = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_MULM = 8'b0001_0000,
    S_MULN = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [VAL_W-1:0]    v_r, v_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic [M_W-1:0]      m_r, m_nxt;
  logic [VAL_W-1:0]    n_r, n_nxt;
  logic [PP_W-1:0]     pp_r, pp_nxt;
  logic                odd_r, odd_nxt;
  logic                zero_r, zero_nxt;

  logic                out_valid_r, out_valid_nxt;
  rs_pkg::status_t     out_status_r, out_status_nxt;
  logic [M_W-1:0]      out_m_r, out_m_nxt;
  logic [VAL_W-1:0]    out_n_r, out_n_nxt;

  logic [VAL_W-1:0]    mul_a, mul_b;
  logic [2*VAL_W-1:0]  mul_prod;
  logic                div_start;
  logic [VAL_W-1:0]    div_dividend;
  rs_pkg::div_stat_t   div_stat;
  logic [VAL_W-1:0]    div_quot;
  logic [P_W-1:0]      div_rem;
  logic                res_load;
  rs_pkg::status_t     res_status;

  rs_div #(
    .VAL_W (VAL_W),
    .P_W   (P_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (p_r),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Select multiplier operands by step: p*p, m*p, n*p or n*v
  always_comb begin
    mul_a = VAL_W'(p_r);
    mul_b = VAL_W'(p_r);
    case (state_r)
      S_MULM: mul_a = VAL_W'(m_r);
      S_MULN: mul_a = n_r;
      S_FIN: begin
        mul_a = n_r;
        mul_b = v_r;
      end
      default: ;
    endcase
  end

  assign mul_prod = (2*VAL_W)'(mul_a) * (2*VAL_W)'(mul_b);

  // Divide the fresh quotient when repeating the same prime
  assign div_dividend = (state_r == S_DIV) ? div_quot : v_r;

  // Classify the finished factorization
  always_comb begin
    if (zero_r)
      res_status = rs_pkg::ST_INVALID;
    else if (n_r == VAL_W'(1))
      res_status = rs_pkg::ST_SQUARE;
    else if (m_r > M_W'(1))
      res_status = rs_pkg::ST_REDUCED;
    else
      res_status = rs_pkg::ST_IRRED;
  end

  assign res_load = (state_r == S_RES) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    pp_nxt    = pp_r;
    odd_nxt   = odd_r;
    zero_nxt  = zero_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          v_nxt    = in_ch.radicand[VAL_W-1:0];
          p_nxt    = P_W'(rs_pkg::FIRST_PRIME);
          odd_nxt  = 1'b0;
          zero_nxt = (in_ch.radicand[VAL_W-1:0] == '0);
          if (in_ch.radicand[VAL_W-1:0] == '0) begin
            m_nxt     = '0;
            n_nxt     = '0;
            state_nxt = S_RES;
          end else begin
            m_nxt     = M_W'(1);
            n_nxt     = VAL_W'(1);
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        pp_nxt    = mul_prod[PP_W-1:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (pp_r > PP_W'(v_r)) begin
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            v_nxt = div_quot;
            if (odd_r) begin
              // second copy of p completes a pair
              odd_nxt   = 1'b0;
              state_nxt = S_MULM;
            end else begin
              odd_nxt   = 1'b1;
              div_start = 1'b1;
            end
          end else if (odd_r) begin
            odd_nxt   = 1'b0;
            state_nxt = S_MULN;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_MULM: begin
        m_nxt     = mul_prod[M_W-1:0];
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_MULN: begin
        n_nxt     = mul_prod[VAL_W-1:0];
        p_nxt     = p_r + 1'b1;
        state_nxt = S_SQ;
      end
      S_FIN: begin
        // leftover value above one is a single prime
        if (v_r > VAL_W'(1))
          n_nxt = mul_prod[VAL_W-1:0];
        state_nxt = S_RES;
      end
      S_RES: begin
        if (res_load)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: load on finish, drop on transfer
  always_comb begin
    out_status_nxt = out_status_r;
    out_m_nxt      = out_m_r;
    out_n_nxt      = out_n_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (res_load) begin
      out_status_nxt = res_status;
      out_m_nxt      = m_r;
      out_n_nxt      = n_r;
      out_valid_nxt  = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    p_r          <= p_nxt;
    m_r          <= m_nxt;
    n_r          <= n_nxt;
    pp_r         <= pp_nxt;
    odd_r        <= odd_nxt;
    zero_r       <= zero_nxt;
    out_status_r <= out_status_nxt;
    out_m_r      <= out_m_nxt;
    out_n_r      <= out_n_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.outer_factor   = rs_pkg::OUTER_W'(out_m_r);
  assign out_ch.inner_radicand = rs_pkg::RADICAND_W'(out_n_r);

endmodule

// ===== rtl/core/rs_checker.sv =====
// Port-level checker for the radical simplifier, bound to the top level.
// Depends on rs_pkg and radical_simplifier_macros.svh.
`include "radical_simplifier_macros.svh"

module rs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input rs_pkg::status_t                out_status,
  input logic [rs_pkg::OUTER_W-1:0]     out_outer,
  input logic [rs_pkg::RADICAND_W-1:0]  out_inner
);

  // Hold a stalled result
  `RS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_outer) && $stable(out_inner), "stalled result changed")

  // Zero input gives zero factors
  `RS_ASSERT_NOW(a_invalid, clk, rst_n, out_valid && out_status == rs_pkg::ST_INVALID, out_outer == '0 && out_inner == '0, "invalid result with nonzero factors")

  // Perfect square leaves one under the root
  `RS_ASSERT_NOW(a_square, clk, rst_n, out_valid && out_status == rs_pkg::ST_SQUARE, out_inner == 16'd1 && out_outer != '0, "perfect square with inner radicand not one")

  // Irreducible keeps the outer factor at one
  `RS_ASSERT_NOW(a_irred, clk, rst_n, out_valid && out_status == rs_pkg::ST_IRRED, out_outer == 8'd1 && out_inner > 16'd1, "irreducible result with outer factor not one")

endmodule

bind radical_simplifier rs_checker u_rs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_outer  (out_ch.outer_factor),
  .out_inner  (out_ch.inner_radicand)
);

// ===== test/radical_simplifier_test.sv =====
// Testbench for radical_simplifier: feeds radicands and checks each
// (status, m, n) result against a trial-division predictor.
// Depends on rs_pkg, rs_in_if, rs_out_if and the radical_simplifier RTL.
`timescale 1ns / 100ps

module radical_simplifier_test;

  localparam int RANDOM_ITEMS = 117;
  localparam int TAIL_CYCLES  = 6000;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Expected simplified root for one radicand
  typedef struct {
    rs_pkg::status_t                status;
    logic [rs_pkg::OUTER_W-1:0]     outer;
    logic [rs_pkg::RADICAND_W-1:0]  inner;
  } root_form_t;

  // Predicts m * sqrt(n) per radicand and matches results in order
  class root_scoreboard;
    root_form_t  pending_roots [$];
    int unsigned radicands_seen;
    int unsigned roots_checked;
    int unsigned status_seen [4];
    int unsigned errors;

    // Factor by trial division from the first prime up to sqrt(rest)
    function root_form_t predict_root(logic [rs_pkg::RADICAND_W-1:0] radicand);
      int unsigned rest;
      int unsigned p;
      int unsigned m;
      int unsigned n;
      int unsigned e;
      root_form_t  form;
      rest = radicand;
      if (rest == 0) begin
        form.status = rs_pkg::ST_INVALID;
        form.outer  = '0;
        form.inner  = '0;
        return form;
      end
      m = 1;
      n = 1;
      p = rs_pkg::FIRST_PRIME;
      while (p * p <= rest) begin
        if (rest % p == 0) begin
          e = 0;
          while (rest % p == 0) begin
            rest = rest / p;
            e++;
          end
          // pairs go outside the root, an odd one stays inside
          while (e >= 2) begin
            m = m * p;
            e = e - 2;
          end
          if (e == 1) n = n * p;
        end
        p++;
      end
      // leftover above one is a single prime
      if (rest > 1) n = n * rest;
      if (n == 1) form.status = rs_pkg::ST_SQUARE;
      else if (m > 1) form.status = rs_pkg::ST_REDUCED;
      else form.status = rs_pkg::ST_IRRED;
      form.outer = m[rs_pkg::OUTER_W-1:0];
      form.inner = n[rs_pkg::RADICAND_W-1:0];
      return form;
    endfunction

    function void note_radicand(logic [rs_pkg::RADICAND_W-1:0] radicand);
      pending_roots.push_back(predict_root(radicand));
      radicands_seen++;
    endfunction

    function void check_root(rs_pkg::status_t status, logic [rs_pkg::OUTER_W-1:0] outer,
                             logic [rs_pkg::RADICAND_W-1:0] inner);
      root_form_t want;
      if (pending_roots.size() == 0) begin
        $error("result with no radicand pending: status %0d m %0d n %0d",
               status, outer, inner);
        errors++;
        return;
      end
      want = pending_roots.pop_front();
      roots_checked++;
      status_seen[want.status]++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (outer !== want.outer) begin
        $error("outer_factor: expected %0d, got %0d", want.outer, outer);
        errors++;
      end
      if (inner !== want.inner) begin
        $error("inner_radicand: expected %0d, got %0d", want.inner, inner);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_roots.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count = 0;
  root_scoreboard ledger = new();

  // Corners: zero, one, tiny primes, max m, high bits, big primes
  logic [rs_pkg::RADICAND_W-1:0] corner_radicands [$] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd12, 16'd16, 16'd18,
    16'd36, 16'd49, 16'd50, 16'd72, 16'd1024, 16'd2048, 16'd32768,
    16'd65025, 16'd65280, 16'd43690, 16'd21845, 16'd65534, 16'd65535,
    16'd65521
  };

  rs_in_if  in_ch ();
  rs_out_if out_ch ();

  radical_simplifier i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radical_simplifier_test: errors");
      $finish;
    end
  end

  // Check each result transfer, then stall the result channel at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        ledger.check_root(out_ch.status, out_ch.outer_factor, out_ch.inner_radicand);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Half small values to keep latency short; some squares times random
  // cofactors, perfect squares, zeros and full-range values
  function automatic logic [rs_pkg::RADICAND_W-1:0] pick_radicand();
    int unsigned roll;
    int unsigned k;
    int unsigned s;
    roll = $urandom_range(99);
    if (roll < 50) return rs_pkg::RADICAND_W'($urandom_range(4095, 1));
    if (roll < 65) begin
      k = $urandom_range(60, 2);
      s = $urandom_range(65535 / (k * k), 1);
      return rs_pkg::RADICAND_W'(k * k * s);
    end
    if (roll < 72) begin
      k = $urandom_range(255, 1);
      return rs_pkg::RADICAND_W'(k * k);
    end
    if (roll < 75) return '0;
    return rs_pkg::RADICAND_W'($urandom_range(65535, 0));
  endfunction

  // Offer one radicand after an optional gap; return at its transfer edge
  task automatic send_radicand(input logic [rs_pkg::RADICAND_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ledger.note_radicand(value);
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.radicand <= '0;
    rst_n          <= 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 57;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_radicands[i]) send_radicand(corner_radicands[i]);

    // Swap the idle pattern partway, then run with no idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 7;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_radicand(pick_radicand());
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (ledger.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d radicands sent, %0d results checked in %0d cycles",
             ledger.radicands_seen, ledger.roots_checked, cycle_count);
    $display("square %0d, reduced %0d, irreducible %0d, zero %0d",
             ledger.status_seen[rs_pkg::ST_SQUARE], ledger.status_seen[rs_pkg::ST_REDUCED],
             ledger.status_seen[rs_pkg::ST_IRRED], ledger.status_seen[rs_pkg::ST_INVALID]);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("radical_simplifier_test: clean");
    end else begin
      $display("radical_simplifier_test: errors");
    end
    $finish;
  end

endmodule
